/* rtl/nmea_sentence_checker_top_macros.svh */
// Assertion helpers shared by the RTL files of the sentence checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef NMEA_SENTENCE_CHECKER_TOP_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NMEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/nmea_chk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nmea_chk_pkg;

	localparam int BUFFER_BYTES = 256;
	localparam int CFG_W        = 9;
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	// Wide enough for position plus two and for the configured limit.
	localparam int CMP_W        = (CNT_W + 1 > CFG_W + 1) ? CNT_W + 1 : CFG_W + 1;
	localparam int MAX_LEN_RESET = 256;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FRAMING  = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef enum logic {
		KIND_FIELD = 1'b0,
		KIND_DONE  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] field_index;
		logic [7:0] field_offset;
		logic [7:0] field_length;
		logic [7:0] page_number;
		logic [7:0] received_checksum;
		logic [7:0] computed_checksum;
		status_t    status;
	} report_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/nmea_sentence_checker_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// A character word is held in the input register, then its result word in the result register.
// Throughput: one character word per cycle while a result-making character is not stalled by
// the output side; the single pass over the sentence state sets this.
// Reset: arst_n clears the sentence state and the valid flags of both pipeline registers
// at once and sets the length limit to 256; no clearing pass is needed.

`include "nmea_sentence_checker_top_macros.svh"

module nmea_sentence_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,     // max_packet_length
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // char_byte
	input  wire logic        s_axis_tlast,  // last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] field_index, [15:8] field_offset, [23:16] field_length, [31:24] page_number,
	// [39:32] received_checksum, [47:40] computed_checksum, [49:48] status, [55:50] zero
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tuser   // report_kind
);

	nmea_chk_pkg::cfg_t    max_len_q;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	logic                  adv;
	logic                  emit;
	nmea_chk_pkg::report_t rpt;
	logic                  out_valid_q;
	nmea_chk_pkg::report_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= nmea_chk_pkg::cfg_t'(nmea_chk_pkg::MAX_LEN_RESET);
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// A character that makes no result never waits for the output side.
	assign adv           = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	nmea_chk_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.char_byte (char_s1),
		.last      (last_s1),
		.max_len   (max_len_q),
		.emit      (emit),
		.rpt       (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= rpt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {6'd0, out_q.status, out_q.computed_checksum, out_q.received_checksum,
		out_q.page_number, out_q.field_length, out_q.field_offset, out_q.field_index};

	`NMEA_ASSERT_NOW(a_no_overwrite, adv && emit, !out_valid_q || m_axis_tready, "result register overwritten")
	`NMEA_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(char_s1) && $stable(last_s1), "stalled character lost")
	`NMEA_ASSERT_NEXT(a_result_loaded, adv && emit, out_valid_q, "result not presented")

endmodule

`default_nettype wire

/* rtl/nmea_chk_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_checker_top_macros.svh"

module nmea_chk_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           char_byte,
	input  wire logic                 last,
	input  wire nmea_chk_pkg::cfg_t   max_len,
	output logic                      emit,
	output nmea_chk_pkg::report_t     rpt
);

	nmea_chk_pkg::cnt_t cnt_q;
	logic [7:0]         xor_q;
	logic               star_seen_q;
	logic               first_dollar_q;
	logic [7:0]         page_q;
	logic               page_open_q;
	logic               field_open_q;
	logic [7:0]         field_cnt_q;
	logic [7:0]         field_start_q;
	logic [3:0]         hex_acc_q;
	logic               hex_valid_q;
	logic               overflowed_q;
	logic               star_back1_q;
	logic               star_back2_q;

	logic               over_now;
	nmea_chk_pkg::cnt_t pos;
	nmea_chk_pkg::cmp_t pos_w;
	nmea_chk_pkg::cmp_t limit;
	logic [7:0]         pos8;
	logic               pos_nz;
	nmea_chk_pkg::hex_t hx;
	logic               is_digit;
	logic [7:0]         page_next;
	logic [7:0]         xor_next;
	logic               is_sep;
	logic [7:0]         received;
	logic               framing_bad;
	logic               too_long;
	logic               mismatch;

	always_comb begin
		over_now = cnt_q >= nmea_chk_pkg::cnt_t'(nmea_chk_pkg::BUFFER_BYTES);
		pos      = over_now ? nmea_chk_pkg::cnt_t'(nmea_chk_pkg::BUFFER_BYTES) : cnt_q;
		pos_w    = nmea_chk_pkg::cmp_t'(pos);
		pos8     = pos_w[7:0];
		pos_nz   = pos != '0;
		hx       = nmea_chk_pkg::hex_decode(char_byte);
		is_digit = char_byte >= 8'h30 && char_byte <= 8'h39;

		// Page times ten is two shifted copies added.
		if (page_open_q && pos_nz && is_digit) begin
			page_next = {page_q[4:0], 3'b000} + {page_q[6:0], 1'b0} + (char_byte - 8'h30);
		end else begin
			page_next = page_q;
		end

		if (!star_seen_q && pos_nz && char_byte != nmea_chk_pkg::CH_STAR) begin
			xor_next = xor_q ^ char_byte;
		end else begin
			xor_next = xor_q;
		end

		is_sep = !star_seen_q &&
			(char_byte == nmea_chk_pkg::CH_COMMA || char_byte == nmea_chk_pkg::CH_STAR);

		if (nmea_chk_pkg::cmp_t'(max_len) < nmea_chk_pkg::cmp_t'(nmea_chk_pkg::BUFFER_BYTES)) begin
			limit = nmea_chk_pkg::cmp_t'(max_len);
		end else begin
			limit = nmea_chk_pkg::cmp_t'(nmea_chk_pkg::BUFFER_BYTES);
		end

		received    = {hex_valid_q ? hex_acc_q : 4'd0, hx.ok ? hx.nib : 4'd0};
		framing_bad = !pos_nz || !first_dollar_q || !star_back2_q;
		too_long    = overflowed_q || over_now || (pos_w + nmea_chk_pkg::cmp_t'(2) > limit);
		mismatch    = !(hex_valid_q && hx.ok) || received != xor_next;
	end

	always_comb begin
		emit = last || (is_sep && field_open_q);
		rpt  = '0;
		if (last) begin
			rpt.kind              = nmea_chk_pkg::KIND_DONE;
			rpt.page_number       = page_next;
			rpt.received_checksum = received;
			rpt.computed_checksum = xor_next;
			if (framing_bad) begin
				rpt.status = nmea_chk_pkg::ST_FRAMING;
			end else if (too_long) begin
				rpt.status = nmea_chk_pkg::ST_TOO_LONG;
			end else if (mismatch) begin
				rpt.status = nmea_chk_pkg::ST_MISMATCH;
			end else begin
				rpt.status = nmea_chk_pkg::ST_OK;
			end
		end else begin
			rpt.kind         = nmea_chk_pkg::KIND_FIELD;
			rpt.field_index  = field_cnt_q;
			rpt.field_offset = field_start_q;
			rpt.field_length = pos8 - field_start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			xor_q          <= '0;
			star_seen_q    <= 1'b0;
			first_dollar_q <= 1'b0;
			page_q         <= '0;
			page_open_q    <= 1'b1;
			field_open_q   <= 1'b0;
			field_cnt_q    <= '0;
			field_start_q  <= '0;
			hex_acc_q      <= '0;
			hex_valid_q    <= 1'b1;
			overflowed_q   <= 1'b0;
			star_back1_q   <= 1'b0;
			star_back2_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				// A finished sentence returns everything to the idle values.
				cnt_q          <= '0;
				xor_q          <= '0;
				star_seen_q    <= 1'b0;
				first_dollar_q <= 1'b0;
				page_q         <= '0;
				page_open_q    <= 1'b1;
				field_open_q   <= 1'b0;
				field_cnt_q    <= '0;
				field_start_q  <= '0;
				hex_acc_q      <= '0;
				hex_valid_q    <= 1'b1;
				overflowed_q   <= 1'b0;
				star_back1_q   <= 1'b0;
				star_back2_q   <= 1'b0;
			end else begin
				if (!over_now) begin
					cnt_q <= cnt_q + nmea_chk_pkg::cnt_t'(1);
				end
				overflowed_q <= overflowed_q | over_now;
				if (!pos_nz) begin
					first_dollar_q <= char_byte == nmea_chk_pkg::CH_DOLLAR;
				end
				xor_q  <= xor_next;
				page_q <= page_next;
				if (pos_nz && !is_digit) begin
					page_open_q <= 1'b0;
				end
				if (is_sep) begin
					if (char_byte == nmea_chk_pkg::CH_COMMA) begin
						field_open_q  <= 1'b1;
						field_start_q <= pos8 + 8'd1;
					end else begin
						field_open_q <= 1'b0;
						star_seen_q  <= 1'b1;
					end
					if (field_open_q) begin
						field_cnt_q <= field_cnt_q + 8'd1;
					end
				end
				star_back2_q <= star_back1_q;
				star_back1_q <= char_byte == nmea_chk_pkg::CH_STAR;
				hex_valid_q  <= hx.ok;
				hex_acc_q    <= hx.ok ? hx.nib : 4'd0;
			end
		end
	end

	`NMEA_ASSERT_NOW(a_field_before_star, step && emit && !last, !star_seen_q && field_open_q, "field word after checksum marker")
	`NMEA_ASSERT_NEXT(a_done_clears, step && last, cnt_q == '0 && !star_seen_q && !field_open_q, "state not cleared after sentence end")
	`NMEA_ASSERT_NEXT(a_star_latches, step && !last && star_seen_q, star_seen_q, "checksum marker flag dropped inside sentence")

endmodule

`default_nettype wire
